FILE: hw/rtl/ece_pkg.sv
`timescale 1ns / 1ps

package ece_pkg;

    // Sizes of the state space and of the edge memory.
    localparam int MAX_STATES  = 32;
    localparam int STATE_W     = 5;
    localparam int MAX_EDGES   = 256;
    localparam int EDGE_ADDR_W = 8;
    localparam int EDGE_CNT_W  = 9;
    localparam int EDGE_W      = 2 * STATE_W;

    // Stream payload widths.
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 8;

    // Symbol byte that marks an epsilon transition ('*').
    localparam logic [7:0] EPSILON_SYMBOL = 8'd42;

    // Operation codes carried in the input beat.
    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_SEED   = 2'd2;
    localparam logic [1:0] OP_RUN    = 2'd3;

    typedef logic [MAX_STATES-1:0] state_mask_t;
    typedef logic [STATE_W-1:0]    state_id_t;

endpackage

FILE: hw/rtl/ece_emitter.sv
`timescale 1ns / 1ps

module ece_emitter (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  ece_pkg::state_mask_t           mask,
    input  logic                           overflow,
    output logic                           busy,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [ece_pkg::M_TDATA_W-1:0]  m_tdata,  // [4:0] state_id, rest zero
    output logic                           m_tlast,
    output logic                           m_tuser   // [0] overflow
);
    import ece_pkg::*;

    state_mask_t pend_reg, pend_next;
    logic        ovf_reg;
    logic        m_valid_reg, m_valid_next;
    state_id_t   m_state_reg;
    logic        m_last_reg;
    logic        m_ovf_reg;

    state_mask_t low_bit;
    state_id_t   low_idx;
    logic        load_out;

    // Isolate the lowest pending member and encode its index.
    always_comb begin
        low_bit = pend_reg & (~pend_reg + state_mask_t'(1));
        low_idx = '0;
        for (int i = 0; i < MAX_STATES; i++) begin
            if (low_bit[i]) begin
                low_idx = low_idx | state_id_t'(i);
            end
        end
    end

    // A new beat enters the output register whenever it is empty or being drained.
    assign load_out = (pend_reg != '0) && (!m_valid_reg || m_tready);

    always_comb begin
        pend_next    = pend_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (start) begin
            pend_next = mask;
        end else if (load_out) begin
            pend_next    = pend_reg & ~low_bit;
            m_valid_next = 1'b1;
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (start) begin
            ovf_reg <= overflow;
        end
        if (!start && load_out) begin
            m_state_reg <= low_idx;
            m_last_reg  <= ((pend_reg & ~low_bit) == '0);
            m_ovf_reg   <= ovf_reg;
        end
    end

    assign busy     = (pend_reg != '0);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - STATE_W){1'b0}}, m_state_reg};
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_ovf_reg;

    // A beat is only loaded when the register is free or draining.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_tready) |=> (m_state_reg == $past(m_state_reg)))
        else $error("output beat overwritten while stalled");

    // Emission never adds members: pending bits only clear between loads.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !start |=> ((pend_reg & ~$past(pend_reg)) == '0))
        else $error("pending mask gained a member without a start");

    // The final beat leaves nothing behind.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (!start && load_out && ((pend_reg & ~low_bit) == '0)) |=> !busy)
        else $error("last beat sent while members remain");

endmodule

FILE: hw/rtl/epsilon_closure_engine.sv
// Clear, append and seed beats are taken in the idle state and can arrive back to back.
// A run sweeps the edge memory once per pass, in order through its single read port,
// repeated until a pass adds no state (at most MAX_STATES passes). Then one closure
// member leaves per cycle while m_tready is high.
// Input is held off from the run beat until the last member is in the output register.
// Reset (aresetn low, synchronous) empties the table and clears seeds and overflow.
`timescale 1ns / 1ps

module epsilon_closure_engine (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [1:0] operation, [6:2] source_state, [14:7] symbol, [19:15] dest_state,
    // [24:20] start_state, rest zero
    input  logic [ece_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [ece_pkg::M_TDATA_W-1:0]  m_tdata,  // [4:0] state_id, rest zero
    output logic                           m_tlast,
    output logic                           m_tuser   // [0] overflow
);
    import ece_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SWEEP  = 2'd1;
    localparam logic [1:0] ST_LAUNCH = 2'd2;
    localparam logic [1:0] ST_DRAIN  = 2'd3;

    logic [1:0]              state_reg, state_next;
    logic [EDGE_CNT_W-1:0]   edge_count_reg, edge_count_next;
    state_mask_t             seed_reg, seed_next;
    state_mask_t             reached_reg, reached_next;
    logic                    ovf_reg, ovf_next;
    logic [EDGE_ADDR_W-1:0]  addr_reg, addr_next;
    logic                    issue_reg, issue_next;
    logic                    rd_valid_reg, rd_valid_next;
    logic                    rd_last_reg, rd_last_next;
    logic                    grew_reg, grew_next;

    logic [EDGE_W-1:0]       edge_mem [MAX_EDGES];
    logic [EDGE_W-1:0]       rdata_reg;
    logic                    wr_en;
    logic                    rd_en;
    logic                    hit;
    logic                    emit_start;
    logic                    emit_busy;

    logic [1:0]              in_op;
    state_id_t               in_src;
    logic [7:0]              in_sym;
    state_id_t               in_dst;
    state_id_t               in_start;
    state_id_t               rd_src;
    state_id_t               rd_dst;

    // Unpack the input beat and the edge read back from memory.
    assign in_op    = s_tdata[1:0];
    assign in_src   = s_tdata[6:2];
    assign in_sym   = s_tdata[14:7];
    assign in_dst   = s_tdata[19:15];
    assign in_start = s_tdata[24:20];
    assign rd_src   = rdata_reg[EDGE_W-1:STATE_W];
    assign rd_dst   = rdata_reg[STATE_W-1:0];

    assign s_tready = (state_reg == ST_IDLE);

    // Operation decode, sweep control and reached-set update.
    always_comb begin
        state_next      = state_reg;
        edge_count_next = edge_count_reg;
        seed_next       = seed_reg;
        reached_next    = reached_reg;
        ovf_next        = ovf_reg;
        addr_next       = addr_reg;
        issue_next      = issue_reg;
        rd_valid_next   = 1'b0;
        rd_last_next    = 1'b0;
        grew_next       = grew_reg;
        wr_en           = 1'b0;
        rd_en           = 1'b0;
        hit             = 1'b0;
        emit_start      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    unique case (in_op)
                        OP_CLEAR: begin
                            edge_count_next = '0;
                            ovf_next        = 1'b0;
                        end
                        OP_APPEND: begin
                            // Every 5-bit state is below MAX_STATES, so only the symbol filters.
                            if (in_sym == EPSILON_SYMBOL) begin
                                if (edge_count_reg == EDGE_CNT_W'(MAX_EDGES)) begin
                                    ovf_next = 1'b1;
                                end else begin
                                    wr_en           = 1'b1;
                                    edge_count_next = edge_count_reg + EDGE_CNT_W'(1);
                                end
                            end
                        end
                        OP_SEED: begin
                            seed_next = seed_reg | (state_mask_t'(1) << in_start);
                        end
                        OP_RUN: begin
                            reached_next = seed_reg;
                            seed_next    = '0;
                            addr_next    = '0;
                            grew_next    = 1'b0;
                            if (edge_count_reg == '0) begin
                                state_next = ST_LAUNCH;
                            end else begin
                                issue_next = 1'b1;
                                state_next = ST_SWEEP;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SWEEP: begin
                // Read side: one edge address a cycle.
                if (issue_reg) begin
                    rd_en         = 1'b1;
                    rd_valid_next = 1'b1;
                    if ({1'b0, addr_reg} == edge_count_reg - EDGE_CNT_W'(1)) begin
                        issue_next   = 1'b0;
                        rd_last_next = 1'b1;
                    end else begin
                        addr_next = addr_reg + EDGE_ADDR_W'(1);
                    end
                end
                // Edge returned from memory: propagate reachability.
                if (rd_valid_reg) begin
                    if (reached_reg[rd_src] && !reached_reg[rd_dst]) begin
                        reached_next[rd_dst] = 1'b1;
                        hit                  = 1'b1;
                    end
                    grew_next = grew_reg | hit;
                end
                // End of a pass: sweep again if anything was added.
                if (rd_valid_reg && rd_last_reg) begin
                    if (grew_reg || hit) begin
                        addr_next  = '0;
                        issue_next = 1'b1;
                        grew_next  = 1'b0;
                    end else begin
                        state_next = ST_LAUNCH;
                    end
                end
            end
            ST_LAUNCH: begin
                emit_start = 1'b1;
                state_next = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (!emit_busy) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            edge_count_reg <= '0;
            seed_reg       <= '0;
            reached_reg    <= '0;
            ovf_reg        <= 1'b0;
            addr_reg       <= '0;
            issue_reg      <= 1'b0;
            rd_valid_reg   <= 1'b0;
            rd_last_reg    <= 1'b0;
            grew_reg       <= 1'b0;
        end else begin
            state_reg      <= state_next;
            edge_count_reg <= edge_count_next;
            seed_reg       <= seed_next;
            reached_reg    <= reached_next;
            ovf_reg        <= ovf_next;
            addr_reg       <= addr_next;
            issue_reg      <= issue_next;
            rd_valid_reg   <= rd_valid_next;
            rd_last_reg    <= rd_last_next;
            grew_reg       <= grew_next;
        end
    end

    // Edge memory: appends write at the fill count, sweeps read in order.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            edge_mem[edge_count_reg[EDGE_ADDR_W-1:0]] <= {in_src, in_dst};
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rdata_reg <= edge_mem[addr_reg];
        end
    end

    ece_emitter u_emitter (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (emit_start),
        .mask     (reached_reg),
        .overflow (ovf_reg),
        .busy     (emit_busy),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // The fill count never passes the memory depth.
    assert property (@(posedge aclk) disable iff (!aresetn)
        edge_count_reg <= EDGE_CNT_W'(MAX_EDGES))
        else $error("edge count beyond memory depth");

    // Read data only arrives while a sweep is in progress.
    assert property (@(posedge aclk) disable iff (!aresetn)
        rd_valid_reg |-> (state_reg == ST_SWEEP))
        else $error("edge read outside a sweep");

    // A sweep only ever adds states to the reached set.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SWEEP) |=> ((reached_reg & $past(reached_reg)) == $past(reached_reg)))
        else $error("reached set lost a member during a sweep");

    // The emitter is only busy after the closure has been handed over.
    assert property (@(posedge aclk) disable iff (!aresetn)
        emit_busy |-> (state_reg == ST_DRAIN))
        else $error("emitter busy outside the drain phase");

endmodule
